>>> rtl/dqa_pkg.sv
package dqa_pkg;

  localparam int HDR_LEN     = 12;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] QR_MASK      = 8'h80;
  localparam logic [7:0] RCODE_KEEP   = 8'hf0;
  localparam logic [7:0] RCODE_NOTIMP = 8'h04;

  // Result count minus one for each kind of command.
  localparam logic [4:0] LAST_HDR_ONLY = 5'd11;
  localparam logic [4:0] LAST_HDR_ANS  = 5'd27;
  localparam logic [4:0] LAST_DATA_ANS = 5'd16;
  localparam logic [4:0] LAST_SINGLE   = 5'd0;

  typedef enum logic [1:0] {
    CMD_DROP,
    CMD_HEADER,
    CMD_DATA
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic [HDR_LEN-1:0][7:0]     hdr;
    logic [7:0]                  data;
    logic                        last;
    logic                        answer;
    logic [31:0]                 ip;
  } cmd_t;

  // Fixed part of the A answer: name pointer, type, class, TTL and length.
  function automatic logic [7:0] answer_head(input logic [3:0] idx);
    logic [7:0] val;
    unique case (idx)
      4'd0:    val = 8'hc0;
      4'd1:    val = 8'h0c;
      4'd2:    val = 8'h00;
      4'd3:    val = 8'h01;
      4'd4:    val = 8'h00;
      4'd5:    val = 8'h01;
      4'd6:    val = 8'h00;
      4'd7:    val = 8'h01;
      4'd8:    val = 8'h51;
      4'd9:    val = 8'h80;
      4'd10:   val = 8'h00;
      4'd11:   val = 8'h04;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/dqa_front.sv
module dqa_front import dqa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic [31:0] answer_ip,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  logic [7:0] hdr [HDR_LEN];
  logic [3:0] pos, pos_next;
  logic       notq, notq_next;
  logic       pending, pending_next;
  logic [HDR_LEN-1:0][7:0] hdr_out;

  // The finished header as it leaves: QR set, then either the answer count's
  // low byte bumped and an answer promised, or rcode set to not implemented.
  always_comb begin
    for (int i = 0; i < HDR_LEN - 1; i++) begin
      hdr_out[i] = hdr[i];
    end
    hdr_out[HDR_LEN-1] = in_byte;
    hdr_out[2] = hdr[2] | QR_MASK;
    if (in_byte == 8'h00) begin
      hdr_out[7] = hdr[7] + 8'd1;
    end else begin
      hdr_out[3] = (hdr[3] & RCODE_KEEP) | RCODE_NOTIMP;
    end
  end

  always_comb begin
    pos_next     = pos;
    notq_next    = notq;
    pending_next = pending;
    cmd_valid    = 1'b0;
    cmd.kind     = CMD_DROP;
    cmd.hdr      = hdr_out;
    cmd.data     = in_byte;
    cmd.last     = in_last;
    cmd.answer   = pending;
    cmd.ip       = answer_ip;
    if (accept) begin
      if (pos < 4'(HDR_LEN - 1)) begin
        pos_next = pos + 4'd1;
        if (pos == 4'd2 && in_byte[7]) begin
          notq_next = 1'b1;
        end
        if (in_last) begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_DROP;
        end
      end else if (pos == 4'(HDR_LEN - 1)) begin
        pos_next = 4'(HDR_LEN);
        if (notq) begin
          cmd_valid = in_last;
          cmd.kind  = CMD_DROP;
        end else begin
          cmd_valid    = 1'b1;
          cmd.kind     = CMD_HEADER;
          cmd.answer   = (in_byte == 8'h00);
          pending_next = (in_byte == 8'h00);
        end
      end else begin
        if (notq) begin
          cmd_valid = in_last;
          cmd.kind  = CMD_DROP;
        end else begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_DATA;
        end
      end
      if (in_last) begin
        pos_next     = 4'd0;
        notq_next    = 1'b0;
        pending_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= 4'd0;
      notq    <= 1'b0;
      pending <= 1'b0;
    end else begin
      pos     <= pos_next;
      notq    <= notq_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos < 4'(HDR_LEN - 1)) begin
      hdr[pos] <= in_byte;
    end
  end

endmodule

>>> rtl/dqa_queue.sv
module dqa_queue import dqa_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output cmd_t rd_cmd
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(Depth));
  assign rd_valid = (count != '0);
  assign rd_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

>>> rtl/dqa_back.sv
module dqa_back import dqa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       dropped,
  output logic       empty,
  input  logic       pop
);

  logic [4:0] cnt;
  logic [4:0] last_idx;
  logic [4:0] ans_idx;
  logic [7:0] ans_byte;
  logic [7:0] nxt_byte;
  logic       out_valid;
  logic       fire;

  always_comb begin
    unique case (cmd.kind)
      CMD_HEADER: begin
        last_idx = (cmd.last && cmd.answer) ? LAST_HDR_ANS : LAST_HDR_ONLY;
        ans_idx  = cnt - 5'(HDR_LEN);
      end
      CMD_DATA: begin
        last_idx = (cmd.last && cmd.answer) ? LAST_DATA_ANS : LAST_SINGLE;
        ans_idx  = cnt - 5'd1;
      end
      default: begin
        last_idx = LAST_SINGLE;
        ans_idx  = cnt;
      end
    endcase
  end

  // The answer ends with the address, most significant byte first.
  always_comb begin
    if (ans_idx[3:0] < 4'(HDR_LEN)) begin
      ans_byte = answer_head(ans_idx[3:0]);
    end else begin
      unique case (ans_idx[1:0])
        2'd0:    ans_byte = cmd.ip[31:24];
        2'd1:    ans_byte = cmd.ip[23:16];
        2'd2:    ans_byte = cmd.ip[15:8];
        default: ans_byte = cmd.ip[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (cmd.kind)
      CMD_HEADER: nxt_byte = (cnt < 5'(HDR_LEN)) ? cmd.hdr[cnt[3:0]] : ans_byte;
      CMD_DATA:   nxt_byte = (cnt == 5'd0) ? cmd.data : ans_byte;
      default:    nxt_byte = 8'h00;
    endcase
  end

  assign fire    = cmd_valid && (!out_valid || pop);
  assign cmd_pop = fire && (cnt == last_idx);
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= 5'd0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        cnt       <= cmd_pop ? 5'd0 : cnt + 5'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte <= nxt_byte;
      out_last <= cmd.last && (cnt == last_idx);
      dropped  <= (cmd.kind == CMD_DROP);
    end
  end

endmodule

>>> rtl/dns_query_to_a_answer_rewriter.sv
// Rewrites a DNS query, taken one byte per request, into an A-record response.
// Input channel: push/full with in_byte, in_last and answer_ip (answer_ip is
// used with the final byte). Result channel: empty/pop with out_byte,
// out_last and dropped; out_last marks the final result of a datagram.
// A datagram that ends before its twelfth byte, or whose QR bit is already
// set, gives one result with dropped and out_last high and out_byte zero.
// The front classifies each byte; the first eleven header bytes give no result
// until byte twelve, which sends the whole rewritten header as one command.
// A queue of QueueDepth commands feeds the back, which emits one result byte
// per cycle while the receiver pops: 12 for the header, 1 per later byte, 16
// for the answer. From an empty queue and output register, a released command
// passes through the queue, then the output register, to the first result.
// Throughput: one byte per cycle while the queue has room; the back emits
// n + 16 result bytes for an answered datagram of n bytes, so full rises during
// the header and answer bursts. A stalled receiver holds the output register,
// the queue then fills and full stops the sender; nothing is lost.
// Reset clears the queue, the output register and the datagram position.
module dns_query_to_a_answer_rewriter import dqa_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic [31:0] answer_ip,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        dropped
);

  logic accept;
  logic fr_valid;
  cmd_t fr_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  assign accept = push && !full;

  dqa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .answer_ip (answer_ip),
    .cmd_valid (fr_valid),
    .cmd       (fr_cmd)
  );

  dqa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fr_valid),
    .wr_cmd   (fr_cmd),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  dqa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .dropped   (dropped),
    .empty     (empty),
    .pop       (pop)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result visible right after reset");

  a_drop_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && dropped) |-> (out_last && out_byte == 8'h00))
    else $error("drop result is not a single zero final byte");

  a_full_has_work: assert property (@(posedge clk) disable iff (rst)
    full |-> q_valid)
    else $error("queue reports full while holding no command");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (q_valid && empty) |=> !empty)
    else $error("waiting command was not moved to the output");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dqa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 180;
  localparam int QUIET_TAIL = 40;
  localparam int PRINT_CAP = 50;

  localparam logic [7:0] ANSWER_PREFIX [12] = '{
    8'hc0, 8'h0c, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01, 8'h51, 8'h80, 8'h00, 8'h04
  };

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       drop;
  } resp_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        in_last;
  logic [31:0] answer_ip;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        dropped;

  // Software copy of the responder state.
  logic [7:0]  hdr_copy [HDR_LEN];
  logic [3:0]  byte_pos;
  logic        not_query;
  logic        answer_due;

  resp_t       expected_resp [$];
  resp_t       head_resp;
  logic [7:0]  pkt [$];
  logic        idling;
  int          stall_left;
  int          errors;
  int          cycles;

  dns_query_to_a_answer_rewriter DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .answer_ip (answer_ip),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .dropped   (dropped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_resp.size());
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic void expect_resp(logic [7:0] data, logic fin, logic drop);
    resp_t r;
    r.data = data;
    r.fin  = fin;
    r.drop = drop;
    expected_resp.push_back(r);
  endfunction

  function automatic void close_datagram();
    byte_pos   = '0;
    not_query  = 1'b0;
    answer_due = 1'b0;
  endfunction

  function automatic void expect_answer(logic [31:0] ip);
    for (int i = 0; i < 12; i++) begin
      expect_resp(ANSWER_PREFIX[i], 1'b0, 1'b0);
    end
    expect_resp(ip[31:24], 1'b0, 1'b0);
    expect_resp(ip[23:16], 1'b0, 1'b0);
    expect_resp(ip[15:8], 1'b0, 1'b0);
    expect_resp(ip[7:0], 1'b1, 1'b0);
  endfunction

  // Works out the responses released by one accepted request.
  function automatic void predict_response(logic [7:0] b, logic fin, logic [31:0] ip);
    if (byte_pos < HDR_LEN) begin
      hdr_copy[byte_pos] = b;
      if (byte_pos == 2 && (b & QR_MASK) != 0) begin
        not_query = 1'b1;
      end
      byte_pos = byte_pos + 4'd1;
      if (byte_pos < HDR_LEN || not_query) begin
        if (fin) begin
          expect_resp(8'h00, 1'b1, 1'b1);
          close_datagram();
        end
        return;
      end
      hdr_copy[2] = hdr_copy[2] | QR_MASK;
      if (hdr_copy[11] == 8'h00) begin
        hdr_copy[7] = hdr_copy[7] + 8'd1;
        answer_due = 1'b1;
      end else begin
        hdr_copy[3] = (hdr_copy[3] & RCODE_KEEP) | RCODE_NOTIMP;
      end
      for (int i = 0; i < HDR_LEN; i++) begin
        expect_resp(hdr_copy[i], fin && !answer_due && i == HDR_LEN - 1, 1'b0);
      end
    end else if (not_query) begin
      if (fin) begin
        expect_resp(8'h00, 1'b1, 1'b1);
        close_datagram();
      end
      return;
    end else begin
      expect_resp(b, fin && !answer_due, 1'b0);
    end
    if (fin) begin
      if (answer_due) begin
        expect_answer(ip);
      end
      close_datagram();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < PRINT_CAP) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  // Result side: compares each popped response and throttles pop in bursts.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_resp.size() == 0) begin
          report_mismatch("unexpected response byte", 32'(out_byte), 32'd0);
        end else begin
          head_resp = expected_resp.pop_front();
          if (out_byte !== head_resp.data) begin
            report_mismatch("out_byte", 32'(out_byte), 32'(head_resp.data));
          end
          if (out_last !== head_resp.fin) begin
            report_mismatch("out_last", 32'(out_last), 32'(head_resp.fin));
          end
          if (dropped !== head_resp.drop) begin
            report_mismatch("dropped", 32'(dropped), 32'(head_resp.drop));
          end
        end
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 9);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Called right after a rising edge; returns right after the edge that takes the request.
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic [31:0] ip);
    int gap;
    gap = 0;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    in_byte   <= b;
    in_last   <= fin;
    answer_ip <= ip;
    do @(posedge clk); while (full);
    predict_response(b, fin, ip);
  endtask

  task automatic send_packet(input logic [31:0] ip);
    for (int i = 0; i < pkt.size(); i++) begin
      if (i == pkt.size() - 1) begin
        send_byte(pkt[i], 1'b1, ip);
      end else begin
        send_byte(pkt[i], 1'b0, $urandom());
      end
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_resp.size() != 0) @(posedge clk);
  endtask

  task automatic fill_packet(input int len);
    pkt.delete();
    repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_short_datagram();
    fill_packet(1);
    send_packet(32'h0000_0000);
    drain();
  endtask

  // Twelve bytes exactly, with the answer count wrapping from ff to 00.
  task automatic test_header_only_answer();
    fill_packet(12);
    pkt[2]  = 8'h01;
    pkt[7]  = 8'hff;
    pkt[11] = 8'h00;
    send_packet(32'hffff_ffff);
    drain();
  endtask

  task automatic test_not_query();
    fill_packet(12);
    pkt[2] = 8'hff;
    send_packet($urandom());
    drain();
  endtask

  // Nonzero byte 11 forces rcode 4 and a plain passthrough of the body.
  task automatic test_not_implemented();
    fill_packet(13);
    pkt[0]  = 8'h00;
    pkt[1]  = 8'hff;
    pkt[2]  = 8'h7f;
    pkt[3]  = 8'hff;
    pkt[11] = 8'hff;
    send_packet($urandom());
    drain();
  endtask

  task automatic test_random_traffic();
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        len = $urandom_range(1, 11);
      end else if (kind == 9) begin
        len = $urandom_range(21, 40);
      end else begin
        len = $urandom_range(12, 20);
      end
      fill_packet(len);
      // Most packets are well-formed queries; kind 8 stays raw noise.
      if (kind != 8 && len > 2) begin
        pkt[2][7] = 1'b0;
        if (len > 11 && $urandom_range(0, 9) < 6) begin
          pkt[11] = 8'h00;
        end
      end
      if (sent >= RANDOM_BYTES - QUIET_TAIL) begin
        idling = 1'b0;
      end
      send_packet($urandom());
      sent += len;
      if ($urandom_range(0, 19) == 0) begin
        drain();
      end
    end
    drain();
  endtask

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    in_byte   = 8'h00;
    in_last   = 1'b0;
    answer_ip = 32'h0;
    idling    = 1'b1;
    errors    = 0;
    cycles    = 0;
    close_datagram();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_datagram();
    test_header_only_answer();
    test_not_query();
    test_not_implemented();
    test_random_traffic();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/dqa_pkg.sv
rtl/dqa_front.sv
rtl/dqa_queue.sv
rtl/dqa_back.sv
rtl/dns_query_to_a_answer_rewriter.sv
tb/sv/testbench.sv
